FILE: hdl/circular_fifo_queue_macros.svh
// Assertion macros used by the circular FIFO checker.
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// Checked only while out of reset.
`define CFQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("circular_fifo_queue: assertion failed");

// Checked on every edge, reset included.
`define CFQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("circular_fifo_queue: assertion failed");

`endif

FILE: hdl/cfq_pkg.sv
// Types and constants of the circular FIFO queue.
package cfq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 9;

    localparam logic [CAP_W-1:0]  CAP_RESET   = 9'd256;
    localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REPORT  = 2'd2
    } cfq_op_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } cfq_in_t;

    typedef struct packed {
        logic                     success;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } cfq_out_t;

    typedef struct packed {
        logic en;
        logic we;
    } cfq_mem_ctl_t;

    // Operation outcome handed from the pointer logic to the result stage.
    typedef struct packed {
        logic              ok;
        logic              upd_rear;
        logic              upd_front_val;
        logic              upd_front_mem;
        logic              is_empty;
        logic              is_full;
        logic [DATA_W-1:0] value;
    } cfq_stage_t;

endpackage

FILE: hdl/cfq_ram.sv
// Single-port slot memory with registered read data.
module cfq_ram import cfq_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              aclk,
    input  cfq_mem_ctl_t      ctl,
    input  logic [AW-1:0]     addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            if (ctl.we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/cfq_ctrl.sv
// Head/tail pointers, empty flag and capacity; issues slot memory accesses.
module cfq_ctrl import cfq_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_acc,
    input  cfq_in_t           in_item,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_data,
    output cfq_mem_ctl_t      mem_ctl,
    output logic [AW-1:0]     mem_addr,
    output logic [DATA_W-1:0] mem_wdata,
    output cfq_stage_t        stage_info
);

    // Capacity clamped to 1..DEPTH, kept as the last usable index.
    function automatic logic [AW-1:0] last_index(input logic [CAP_W-1:0] cap);
        int eff;
        eff = int'(cap);
        if (eff == 0) begin
            eff = 1;
        end else if (eff > DEPTH) begin
            eff = DEPTH;
        end
        return AW'(eff - 1);
    endfunction

    localparam logic [AW-1:0] LAST_RESET = last_index(CAP_RESET);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] head_inc, tail_inc;
    logic          same, q_empty, q_full;

    always_comb begin
        head_inc = (head_reg == last_reg) ? '0 : head_reg + AW'(1);
        tail_inc = (tail_reg == last_reg) ? '0 : tail_reg + AW'(1);
        same     = (head_reg == tail_reg);
        q_empty  = same && empty_reg;
        q_full   = same && !empty_reg;
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        last_next  = last_reg;
        mem_ctl    = '0;
        mem_addr   = tail_reg;
        mem_wdata  = in_item.value;
        stage_info = '0;
        stage_info.value = in_item.value;
        stage_info.ok    = 1'b1;

        if (cfg_we) begin
            last_next  = last_index(cfg_data);
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
        end else if (in_acc) begin
            case (in_item.operation)
                OP_ENQUEUE: begin
                    if (q_full) begin
                        stage_info.ok = 1'b0;
                    end else begin
                        mem_ctl.en  = 1'b1;
                        mem_ctl.we  = 1'b1;
                        tail_next   = tail_inc;
                        empty_next  = 1'b0;
                        stage_info.upd_rear      = 1'b1;
                        stage_info.upd_front_val = q_empty;
                    end
                end
                OP_DEQUEUE: begin
                    if (q_empty) begin
                        stage_info.ok = 1'b0;
                    end else begin
                        // fetch the new front; unused if the queue drains
                        mem_ctl.en  = 1'b1;
                        mem_addr    = head_inc;
                        head_next   = head_inc;
                        empty_next  = (head_inc == tail_reg);
                        stage_info.upd_front_mem = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        stage_info.is_empty = (head_next == tail_next) && empty_next;
        stage_info.is_full  = (head_next == tail_next) && !empty_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            last_reg  <= LAST_RESET;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            last_reg  <= last_next;
        end
    end

endmodule

FILE: hdl/circular_fifo_queue.sv
// Top level of the circular FIFO queue: pointer logic, slot memory, result stage.
//
//  channel   dir  handshake             payload
//  s_        in   s_valid / s_ready     cfq_in_t  (operation, value)
//  m_        out  m_valid / m_ready     cfq_out_t (success, front, rear, empty, full)
//  cfg_      in   cfg_valid / cfg_ready capacity, 9 bits
//
// One operation per cycle while the m_ channel does not stall; after its transfer a result passes
// the result stage, registered with the slot memory read of the new front, then the output register.
// Front and rear values are kept in registers; only a dequeue reads the memory.
// A stalled m_ channel holds a valid result stage, and s_ready drops with it.
// Reset empties the queue at once; cfg_ready is always high and a write empties it too.
module circular_fifo_queue import cfq_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cfq_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cfq_out_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfq_mem_ctl_t      mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    cfq_stage_t        stage_info;

    logic              s_acc, b_adv;
    logic              b_valid_reg, b_valid_next;
    cfq_stage_t        b_info_reg;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] rear_reg, rear_next;
    logic              m_valid_reg, m_valid_next;
    cfq_out_t          m_data_reg, m_data_next;

    assign cfg_ready = 1'b1;
    assign b_adv     = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !b_valid_reg || b_adv;
    assign s_acc     = s_valid && s_ready;

    cfq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_acc     (s_acc),
        .in_item    (s_data),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .stage_info (stage_info)
    );

    cfq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        if (b_info_reg.upd_front_mem) begin
            front_next = mem_rdata;
        end else if (b_info_reg.upd_front_val) begin
            front_next = b_info_reg.value;
        end
        if (b_info_reg.upd_rear) begin
            rear_next = b_info_reg.value;
        end

        m_data_next.success     = b_info_reg.ok;
        m_data_next.front_value = b_info_reg.is_empty ? EMPTY_VALUE : front_next;
        m_data_next.rear_value  = b_info_reg.is_empty ? EMPTY_VALUE : rear_next;
        m_data_next.is_empty    = b_info_reg.is_empty;
        m_data_next.is_full     = b_info_reg.is_full;

        b_valid_next = b_valid_reg;
        if (s_acc) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (b_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_info_reg <= stage_info;
        end
        if (b_adv) begin
            front_reg  <= front_next;
            rear_reg   <= rear_next;
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/cfq_checker.sv
// Port-level checks of the circular FIFO queue and their bind.
`include "circular_fifo_queue_macros.svh"

module cfq_checker import cfq_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input cfq_out_t m_data
);

    logic empty_marks;

    assign empty_marks = (m_data.front_value == EMPTY_VALUE) &&
                         (m_data.rear_value == EMPTY_VALUE);

    `CFQ_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `CFQ_ASSERT(a_empty_values, aclk, aresetn, m_valid && m_data.is_empty |-> empty_marks)
    `CFQ_ASSERT(a_not_empty_and_full, aclk, aresetn, m_valid |-> !(m_data.is_empty && m_data.is_full))
    `CFQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
